/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl modules
// assumes clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BFDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define BFDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bfda_pkg.sv */
// package for the fixed-point to decimal ascii converter
// constants, pipeline word type; no dependencies
`default_nettype none

package bfda_pkg;

  localparam int unsigned InW       = 32;
  localparam int unsigned ValW      = 18;
  localparam int unsigned ScaleGrow = 7;
  localparam int unsigned ProdW     = ValW + ScaleGrow;
  localparam int unsigned ScaleShift = 8;
  localparam int unsigned HoldW     = ProdW - ScaleShift;
  localparam int unsigned NumDigits = 5;
  localparam int unsigned BcdW      = 4 * NumDigits;

  localparam int unsigned ShiftsA = 6;
  localparam int unsigned ShiftsB = 6;
  localparam int unsigned ShiftsC = HoldW - ShiftsA - ShiftsB;

  localparam logic [InW-1:0] ConvLimit = 32'd256000;

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharBlank = 8'h20;
  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharStar  = 8'h2A;

  typedef struct packed {
    logic             oor;
    logic [HoldW-1:0] bin;
    logic [BcdW-1:0]  bcd;
  } bfda_word_t;

endpackage

`default_nettype wire

/* hw/rtl/bfda_dabble_stage.sv */
// one registered binary to bcd stage, NumShifts shift-add-3 steps per stage
// depends on bfda_pkg
`default_nettype none

module bfda_dabble_stage import bfda_pkg::*; #(
  parameter int unsigned NumShifts = ShiftsA
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire bfda_word_t in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output bfda_word_t      out_word_o
);

  function automatic bfda_word_t dabble(bfda_word_t w);
    bfda_word_t r;
    r = w;
    for (int s = 0; s < NumShifts; s++) begin
      for (int n = 0; n < NumDigits; n++) begin
        if (r.bcd[n*4 +: 4] >= 4'd5) begin
          r.bcd[n*4 +: 4] = r.bcd[n*4 +: 4] + 4'd3;
        end
      end
      r.bcd = {r.bcd[BcdW-2:0], r.bin[HoldW-1]};
      r.bin = {r.bin[HoldW-2:0], 1'b0};
    end
    return r;
  endfunction

  logic       valid_q;
  bfda_word_t word_q;
  bfda_word_t word_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign word_d      = dabble(in_word_i);
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/binary_fixed_to_decimal_ascii_top.sv */
// top level: fixed-point (1/256) to six ascii characters "ddd.dd"
// depends on bfda_pkg, bfda_dabble_stage, assert_macros.svh
//
// channel   dir  fields                                   per item
// s_axis    in   tdata[31:0] fixed_value                  one value
// m_axis    out  tdata[7:0] ascii_char, tlast last_char   six characters
//
// a value passes a scale register and three bcd conversion registers, then
// a serializer register that sends one character per cycle while m_axis is
// ready; when full, it takes the next value only with its last character's transfer.
// up to four more values queue in the pipeline. reset clears the valid bits
// and the character index only. a stall on m_axis holds every full stage.
`default_nettype none

`include "assert_macros.svh"

module binary_fixed_to_decimal_ascii_top import bfda_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire logic [InW-1:0] s_axis_tdata,   // [31:0] fixed_value
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] ascii_char
  output logic                m_axis_tlast    // last_char
);

  localparam logic [2:0] PosHundreds = 3'd0;
  localparam logic [2:0] PosTens     = 3'd1;
  localparam logic [2:0] PosUnits    = 3'd2;
  localparam logic [2:0] PosPoint    = 3'd3;
  localparam logic [2:0] PosTenths   = 3'd4;
  localparam logic [2:0] PosLast     = 3'd5;

  // scale stage
  logic             s1_valid_q;
  bfda_word_t       s1_word_q;
  bfda_word_t       s1_word_d;
  logic             s1_ready;
  logic [ValW-1:0]  val;
  logic [ProdW-1:0] prod;

  assign val  = s_axis_tdata[ValW-1:0];
  assign prod = {1'b0, val, 6'b0} + {2'b0, val, 5'b0} + {5'b0, val, 2'b0};

  always_comb begin
    s1_word_d     = '0;
    s1_word_d.oor = s_axis_tdata >= ConvLimit;
    s1_word_d.bin = prod[ProdW-1:ScaleShift];
  end

  assign s_axis_tready = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_word_q <= s1_word_d;
    end
  end

  // bcd conversion stages
  logic       a_valid, a_ready, b_valid, b_ready, c_valid, c_ready;
  bfda_word_t a_word, b_word, c_word;

  bfda_dabble_stage #(.NumShifts(ShiftsA)) u_stage_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (s1_ready),
    .in_word_i   (s1_word_q),
    .out_valid_o (a_valid),
    .out_ready_i (a_ready),
    .out_word_o  (a_word)
  );

  bfda_dabble_stage #(.NumShifts(ShiftsB)) u_stage_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_valid),
    .in_ready_o  (a_ready),
    .in_word_i   (a_word),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_word_o  (b_word)
  );

  bfda_dabble_stage #(.NumShifts(ShiftsC)) u_stage_c (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .in_word_i   (b_word),
    .out_valid_o (c_valid),
    .out_ready_i (c_ready),
    .out_word_o  (c_word)
  );

  // serializer
  logic            ser_valid_q;
  logic [2:0]      ser_idx_q;
  logic            ser_oor_q;
  logic [BcdW-1:0] ser_bcd_q;
  logic [3:0]      d4, d3, d2, d1, d0;
  logic            out_xfer;

  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign c_ready  = !ser_valid_q || (m_axis_tready && ser_idx_q == PosLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      ser_idx_q   <= PosHundreds;
    end else if (c_ready) begin
      ser_valid_q <= c_valid;
      ser_idx_q   <= PosHundreds;
    end else if (out_xfer) begin
      ser_idx_q <= ser_idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && c_valid) begin
      ser_oor_q <= c_word.oor;
      ser_bcd_q <= c_word.bcd;
    end
  end

  assign d4 = ser_bcd_q[19:16];
  assign d3 = ser_bcd_q[15:12];
  assign d2 = ser_bcd_q[11:8];
  assign d1 = ser_bcd_q[7:4];
  assign d0 = ser_bcd_q[3:0];

  always_comb begin
    case (ser_idx_q)
      PosHundreds: m_axis_tdata = ser_oor_q ? CharStar :
                                  (d4 != 4'd0) ? CharZero + {4'b0, d4} : CharBlank;
      PosTens:     m_axis_tdata = ser_oor_q ? CharStar :
                                  (d4 != 4'd0 || d3 != 4'd0) ? CharZero + {4'b0, d3}
                                                             : CharBlank;
      PosUnits:    m_axis_tdata = ser_oor_q ? CharStar : CharZero + {4'b0, d2};
      PosPoint:    m_axis_tdata = CharPoint;
      PosTenths:   m_axis_tdata = ser_oor_q ? CharStar : CharZero + {4'b0, d1};
      PosLast:     m_axis_tdata = ser_oor_q ? CharStar : CharZero + {4'b0, d0};
      default:     m_axis_tdata = CharStar;
    endcase
  end

  assign m_axis_tvalid = ser_valid_q;
  assign m_axis_tlast  = ser_idx_q == PosLast;

  `BFDA_ASSERT_NXT(a_idx_step, out_xfer && !m_axis_tlast,
    m_axis_tvalid && ser_idx_q == 3'($past(ser_idx_q) + 3'd1), "char index did not advance")
  `BFDA_ASSERT_NXT(a_drain, out_xfer && m_axis_tlast && !c_valid,
    !m_axis_tvalid, "serializer still valid after its last character")
  `BFDA_ASSERT_IMP(a_bcd_digits, ser_valid_q && !ser_oor_q,
    d4 <= 4'd9 && d3 <= 4'd9 && d2 <= 4'd9 && d1 <= 4'd9 && d0 <= 4'd9,
    "bcd digit out of range")

endmodule

`default_nettype wire

/* tb/ascii_field_checker.sv */
`timescale 1ns / 1ps
// checker for the fixed-point to decimal ascii converter: predicts the six
// characters of every accepted value and compares the output stream; uses bfda_pkg
module ascii_field_checker import bfda_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  input  logic           s_axis_tready,
  input  logic [InW-1:0] s_axis_tdata,
  input  logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  input  logic [7:0]     m_axis_tdata,
  input  logic           m_axis_tlast,
  output int             fail_count_o,
  output int             pending_o
);

  localparam int unsigned FieldLen    = 6;
  localparam int unsigned ScaleFactor = 100;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_beat_t;

  char_beat_t expected_chars[$];
  int         char_index;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    char_index   = 0;
  end

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("%0t ns: char %0d %s: expected 0x%0h, got 0x%0h",
             $time, char_index, what, want, got);
    fail_count_o++;
  endtask

  // hundredths = value * 100 >> 8, then blank-suppressed "ddd.dd"; stars and the point when out of range
  function automatic void predict_field(logic [InW-1:0] value);
    logic [7:0]  field [FieldLen];
    logic [63:0] hold;
    bit          hundreds_shown;
    if (value >= ConvLimit) begin
      field = '{CharStar, CharStar, CharStar, CharPoint, CharStar, CharStar};
    end else begin
      hold = ({32'd0, value} * 64'(ScaleFactor)) >> ScaleShift;
      hundreds_shown = hold > 64'd9999;
      field[0] = hundreds_shown ? CharZero + 8'(hold / 10000) : CharBlank;
      hold = hold % 10000;
      field[1] = (hundreds_shown || hold > 64'd999) ? CharZero + 8'(hold / 1000) : CharBlank;
      hold = hold % 1000;
      field[2] = CharZero + 8'(hold / 100);
      hold = hold % 100;
      field[3] = CharPoint;
      field[4] = CharZero + 8'(hold / 10);
      field[5] = CharZero + 8'(hold % 10);
    end
    for (int k = 0; k < FieldLen; k++) begin
      expected_chars.push_back('{code: field[k], last: (k == FieldLen - 1)});
    end
  endfunction

  always @(posedge clk_i) begin
    char_beat_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_field(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected transfer", 0, m_axis_tdata);
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.code) report_mismatch("ascii_char", want.code, m_axis_tdata);
          if (m_axis_tlast !== want.last) report_mismatch("last_char", want.last, m_axis_tlast);
        end
        char_index++;
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// testbench top for the fixed-point to decimal ascii converter: clock, reset,
// value stimulus, output back-pressure and verdict; uses bfda_pkg and ascii_field_checker
module tb;
  import bfda_pkg::*;

  localparam int unsigned RandomCount = 190;
  localparam int unsigned QuietTail   = 40;
  localparam int unsigned LongStall   = 80;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned DrainLimit  = 5000;

  // hold boundaries, zero tens under a hundreds digit, out-of-range edges
  localparam logic [InW-1:0] Directed [21] = '{
    32'd0, 32'd1, 32'd3, 32'd255, 32'd256, 32'd2559, 32'd2560, 32'd25599,
    32'd25600, 32'd25728, 32'd26880, 32'd123456, 32'd255999, 32'd256000,
    32'd256001, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h55555555,
    32'hAAAAAAAA, 32'd128
  };

  logic           clk    = 1'b0;
  logic           rst_n  = 1'b0;
  logic           s_valid = 1'b0;
  logic [InW-1:0] s_data  = '0;
  logic           s_ready;
  logic           m_valid;
  logic           m_ready = 1'b0;
  logic [7:0]     m_data;
  logic           m_last;
  bit             idle_on       = 1'b1;
  bit             long_stall_go = 1'b0;
  int             fail_count;
  int             pending;

  binary_fixed_to_decimal_ascii_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  ascii_field_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // output back-pressure, with one long hold-off so the pipeline fills
  initial begin : sink
    int stall_left;
    bit long_done;
    stall_left = 0;
    long_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_go && !long_done) begin
        long_done  = 1'b1;
        stall_left = LongStall;
      end
      if (stall_left > 0) begin
        m_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_value(logic [InW-1:0] value);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= value;
    do @(posedge clk); while (!s_ready);
    @(negedge clk);
  endtask

  function automatic logic [InW-1:0] random_value();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2:    return ConvLimit - 32'd4 + $urandom_range(0, 7);
      3:    return $urandom_range(0, 2600);
      4:    return ($urandom_range(0, 1) ? 32'd2560 : 32'd25600) - 32'd3 + $urandom_range(0, 6);
      default: return $urandom_range(0, 255999);
    endcase
  endfunction

  initial begin : stimulus
    int remaining;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (Directed[i]) send_value(Directed[i]);
    for (int i = 0; i < RandomCount; i++) begin
      if (i == 30) long_stall_go = 1'b1;
      if (i == RandomCount - QuietTail) idle_on = 1'b0;
      send_value(random_value());
    end
    s_valid <= 1'b0;
    remaining = DrainLimit;
    while (pending != 0 && remaining > 0) begin
      @(negedge clk);
      remaining--;
    end
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bfda_pkg.sv
hw/rtl/bfda_dabble_stage.sv
hw/rtl/binary_fixed_to_decimal_ascii_top.sv
tb/ascii_field_checker.sv
tb/tb.sv
